[hw/rtl/wlan_client_address_collector_defines.svh]
// Assertion macros used by the collector's top level.
`ifndef WLAN_CLIENT_ADDRESS_COLLECTOR_DEFINES_SVH
`define WLAN_CLIENT_ADDRESS_COLLECTOR_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define CAC_ASSERT_HOLDS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// When the trigger is seen, the condition must hold in the next cycle.
`define CAC_ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

[hw/rtl/cac_pkg.sv]
package cac_pkg;

  // Table geometry and frame limits.
  localparam int TABLE_DEPTH     = 64;
  localparam int IDX_W           = $clog2(TABLE_DEPTH);
  localparam int CNT_W           = $clog2(TABLE_DEPTH + 1);
  localparam int MIN_FRAME_BYTES = 24;
  localparam int ADDR_W          = 48;
  localparam int LEN_W           = 12;

  localparam logic [ADDR_W-1:0] BROADCAST_ADDR = {ADDR_W{1'b1}};

  // Command codes; code 3 does nothing.
  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_CLEAR   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Frame kind codes that are used.
  localparam logic [1:0] KIND_MGMT = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENABLE = 2'd0;
  localparam logic [1:0] CFG_TARGET = 2'd1;

  typedef struct packed {
    logic [1:0]        command;
    logic [1:0]        frame_kind;
    logic [LEN_W-1:0]  frame_length;
    logic [ADDR_W-1:0] addr_one;
    logic [ADDR_W-1:0] addr_two;
    logic [5:0]        read_index;
  } cac_in_item_t;

  typedef struct packed {
    logic              client_found;
    logic [ADDR_W-1:0] client_address;
    logic              newly_added;
    logic              dropped_full;
    logic [6:0]        entry_count;
    logic [ADDR_W-1:0] entry_address;
  } cac_out_item_t;

  typedef struct packed {
    logic [1:0]        reg_index;
    logic [ADDR_W-1:0] wdata;
  } cac_cfg_item_t;

  // Decoded client of an observed frame.
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] client;
  } cac_filter_t;

  // Access to the client table memory.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ADDR_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } cac_mem_req_t;

  // Controller status seen by the top level.
  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } cac_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPEND,
    ST_RDWAIT,
    ST_FINISH
  } cac_state_t;

endpackage

[hw/rtl/cac_chan_if.sv]
// Valid/ready channel carrying one item per handshake.
interface cac_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/cac_client_mem.sv]
module cac_client_mem (
  input  logic                              clk,
  input  cac_pkg::cac_mem_req_t             req_i,
  output logic [cac_pkg::ADDR_W-1:0]        rdata_o
);
  import cac_pkg::*;

  logic [ADDR_W-1:0] mem [TABLE_DEPTH];
  logic [ADDR_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (req_i.re) begin
      rdata_r <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_r;
endmodule

[hw/rtl/cac_frame_filter.sv]
module cac_frame_filter (
  input  logic                       enable_i,
  input  logic [cac_pkg::ADDR_W-1:0] target_i,
  input  cac_pkg::cac_in_item_t      item_i,
  output cac_pkg::cac_filter_t       filt_o
);
  import cac_pkg::*;

  logic usable;
  logic a1_is_tgt;
  logic a2_is_tgt;

  // A frame counts only when enabled, of a known kind and long enough.
  assign usable = enable_i
                  && (item_i.frame_kind == KIND_MGMT || item_i.frame_kind == KIND_DATA)
                  && (item_i.frame_length >= LEN_W'(MIN_FRAME_BYTES));

  assign a1_is_tgt = (item_i.addr_one == target_i);
  assign a2_is_tgt = (item_i.addr_two == target_i);

  // Address 2 is the client when the frame goes to the access point,
  // address 1 when it comes from it to a single station.
  always_comb begin
    filt_o = '0;
    if (usable) begin
      if (a1_is_tgt && !a2_is_tgt) begin
        filt_o.found  = 1'b1;
        filt_o.client = item_i.addr_two;
      end else if (a2_is_tgt && !a1_is_tgt && item_i.addr_one != BROADCAST_ADDR) begin
        filt_o.found  = 1'b1;
        filt_o.client = item_i.addr_one;
      end
    end
  end
endmodule

[hw/rtl/cac_ctrl.sv]
module cac_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  cac_pkg::cac_in_item_t       in_item_i,
  input  cac_pkg::cac_filter_t        filt_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output cac_pkg::cac_out_item_t      out_item_o,
  output cac_pkg::cac_mem_req_t       mem_req_o,
  input  logic [cac_pkg::ADDR_W-1:0]  mem_rdata_i,
  output cac_pkg::cac_status_t        status_o
);
  import cac_pkg::*;

  cac_state_t        state_r,   state_nxt;
  logic [CNT_W-1:0]  count_r,   count_nxt;
  logic [IDX_W-1:0]  idx_r,     idx_nxt;
  logic              found_r,   found_nxt;
  logic [ADDR_W-1:0] client_r,  client_nxt;
  logic              added_r,   added_nxt;
  logic              dropped_r, dropped_nxt;
  logic [ADDR_W-1:0] entry_r,   entry_nxt;
  logic              out_valid_r, out_valid_nxt;
  cac_out_item_t     out_item_r,  out_item_nxt;
  logic              accept;
  logic              last_slot;

  assign in_ready_o = (state_r == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign last_slot  = (({1'b0, idx_r} + CNT_W'(1)) == count_r);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    client_r   <= client_nxt;
    added_r    <= added_nxt;
    dropped_r  <= dropped_nxt;
    entry_r    <= entry_nxt;
    out_item_r <= out_item_nxt;
  end

  // Sequencer: decode, linear table search, append, read, hand off result.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    client_nxt    = client_r;
    added_nxt     = added_r;
    dropped_nxt   = dropped_r;
    entry_nxt     = entry_r;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r && !out_ready_i;
    mem_req_o     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          found_nxt   = 1'b0;
          client_nxt  = '0;
          added_nxt   = 1'b0;
          dropped_nxt = 1'b0;
          entry_nxt   = '0;
          idx_nxt     = '0;
          state_nxt   = ST_FINISH;
          unique case (in_item_i.command)
            CMD_OBSERVE: begin
              found_nxt  = filt_i.found;
              client_nxt = filt_i.client;
              if (filt_i.found) begin
                if (count_r == '0) begin
                  state_nxt = ST_APPEND;
                end else begin
                  mem_req_o.re    = 1'b1;
                  mem_req_o.raddr = '0;
                  state_nxt       = ST_SEARCH;
                end
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_READ: begin
              if ({1'b0, in_item_i.read_index} < count_r) begin
                mem_req_o.re    = 1'b1;
                mem_req_o.raddr = IDX_W'(in_item_i.read_index);
                state_nxt       = ST_RDWAIT;
              end
            end
            default: begin
              state_nxt = ST_FINISH;
            end
          endcase
        end
      end

      // Read data belongs to slot idx_r; the next slot is fetched meanwhile.
      ST_SEARCH: begin
        if (mem_rdata_i == client_r) begin
          state_nxt = ST_FINISH;
        end else if (last_slot) begin
          state_nxt = ST_APPEND;
        end else begin
          idx_nxt         = idx_r + IDX_W'(1);
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = idx_r + IDX_W'(1);
        end
      end

      ST_APPEND: begin
        if (count_r < CNT_W'(TABLE_DEPTH)) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = count_r[IDX_W-1:0];
          mem_req_o.wdata = client_r;
          count_nxt       = count_r + CNT_W'(1);
          added_nxt       = 1'b1;
        end else begin
          dropped_nxt = 1'b1;
        end
        state_nxt = ST_FINISH;
      end

      ST_RDWAIT: begin
        entry_nxt = mem_rdata_i;
        state_nxt = ST_FINISH;
      end

      // Load the output register once it is free.
      ST_FINISH: begin
        if (!out_valid_r || out_ready_i) begin
          out_item_nxt.client_found   = found_r;
          out_item_nxt.client_address = client_r;
          out_item_nxt.newly_added    = added_r;
          out_item_nxt.dropped_full   = dropped_r;
          out_item_nxt.entry_count    = 7'(count_r);
          out_item_nxt.entry_address  = entry_r;
          out_valid_nxt               = 1'b1;
          state_nxt                   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o    = out_valid_r;
  assign out_item_o     = out_item_r;
  assign status_o.busy  = (state_r != ST_IDLE);
  assign status_o.count = count_r;
endmodule

[hw/rtl/wlan_client_address_collector.sv]
// Path of an item: clear, no-op, an ignored frame and a read beyond the count go
// straight to the finish state; a read passes the read-wait state; a known client ends
// the search at its entry; a new client is appended after searching all N (N <= 64).
// Throughput: one item at a time; the next item is accepted once the result sits in
// the output register, so the one-entry-per-cycle table search sets the bound.
// Reset (synchronous, rst_n low): count and config zero, no result held, table kept.
module wlan_client_address_collector (
  input  logic       clk,
  input  logic       rst_n,
  cac_chan_if.sink   in_ch,
  cac_chan_if.source out_ch,
  cac_chan_if.sink   cfg_ch
);
  import cac_pkg::*;

`include "wlan_client_address_collector_defines.svh"

  logic              enable_r, enable_nxt;
  logic [ADDR_W-1:0] target_r, target_nxt;
  logic              cfg_write;
  cac_in_item_t      in_item;
  cac_cfg_item_t     cfg_item;
  cac_out_item_t     out_item;
  cac_filter_t       filt;
  cac_mem_req_t      mem_req;
  logic [ADDR_W-1:0] mem_rdata;
  cac_status_t       status;

  assign in_item      = in_ch.data;
  assign cfg_item     = cfg_ch.data;
  assign cfg_ch.ready = 1'b1;
  assign cfg_write    = cfg_ch.valid && cfg_ch.ready;

  // Configuration registers.
  always_comb begin
    enable_nxt = enable_r;
    target_nxt = target_r;
    if (cfg_write) begin
      unique case (cfg_item.reg_index)
        CFG_ENABLE: enable_nxt = cfg_item.wdata[0];
        CFG_TARGET: target_nxt = cfg_item.wdata;
        default:    enable_nxt = enable_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      target_r <= '0;
    end else begin
      enable_r <= enable_nxt;
      target_r <= target_nxt;
    end
  end

  cac_frame_filter u_filter (
    .enable_i (enable_r),
    .target_i (target_r),
    .item_i   (in_item),
    .filt_o   (filt)
  );

  cac_client_mem u_mem (
    .clk     (clk),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  cac_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .in_item_i   (in_item),
    .filt_i      (filt),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_item_o  (out_item),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .status_o    (status)
  );

  assign out_ch.data = out_item;

  // The count never runs past the table size.
  `CAC_ASSERT_HOLDS(a_count_bound, clk, rst_n, status.count <= CNT_W'(TABLE_DEPTH),
                    "count above table size")
  // An accepted item keeps the controller busy in the next cycle.
  `CAC_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_ch.valid && in_ch.ready, status.busy,
                   "accepted item not in work")
  // A client is never both appended and dropped.
  `CAC_ASSERT_HOLDS(a_add_xor_drop, clk, rst_n,
                    !(out_ch.valid && out_item.newly_added && out_item.dropped_full),
                    "added and dropped together")
  // Appending only happens for a found client.
  `CAC_ASSERT_HOLDS(a_add_found, clk, rst_n,
                    !(out_ch.valid && out_item.newly_added && !out_item.client_found),
                    "added without a client")
endmodule

[dv/tb_wlan_client_address_collector.sv]
`timescale 1ns / 100ps

module tb_wlan_client_address_collector;
  import cac_pkg::*;

  // Codes that the package leaves unnamed.
  localparam logic [1:0] CMD_NOP       = 2'd3;
  localparam logic [1:0] KIND_OTHER    = 2'd2;
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam logic [1:0] CFG_SPARE_A   = 2'd2;
  localparam logic [1:0] CFG_SPARE_B   = 2'd3;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int CFG_PAUSE    = 4;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_PCT     = 30;
  localparam int POOL_MAX     = 128;

  logic clk;
  logic rst_n;

  cac_chan_if #(.payload_t(cac_in_item_t))  in_ch ();
  cac_chan_if #(.payload_t(cac_out_item_t)) out_ch ();
  cac_chan_if #(.payload_t(cac_cfg_item_t)) cfg_ch ();

  wlan_client_address_collector DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Items waiting to be sent, register writes waiting, and reports still due.
  cac_in_item_t  frames_to_send[$];
  cac_cfg_item_t reg_writes[$];
  cac_out_item_t expected_reports[$];

  // Shadow copy of the client table and the registers.
  logic [ADDR_W-1:0] known_clients[TABLE_DEPTH];
  int unsigned       known_count;
  logic              shadow_enable;
  logic [ADDR_W-1:0] shadow_target;

  bit steady;
  int errors;
  int cycles;

  // Works out the report for one item and updates the shadow table.
  function automatic cac_out_item_t track_client_table(cac_in_item_t it);
    cac_out_item_t r;
    logic          hit;
    int            i;
    r = '0;
    case (it.command)
      CMD_OBSERVE: begin
        if (shadow_enable && (it.frame_kind == KIND_MGMT || it.frame_kind == KIND_DATA)
            && it.frame_length >= MIN_FRAME_BYTES) begin
          if (it.addr_one == shadow_target && it.addr_two != shadow_target) begin
            r.client_found   = 1'b1;
            r.client_address = it.addr_two;
          end else if (it.addr_two == shadow_target && it.addr_one != BROADCAST_ADDR
                       && it.addr_one != shadow_target) begin
            r.client_found   = 1'b1;
            r.client_address = it.addr_one;
          end
        end
        if (r.client_found) begin
          hit = 1'b0;
          for (i = 0; i < known_count; i++) begin
            if (known_clients[i] == r.client_address) hit = 1'b1;
          end
          if (!hit) begin
            if (known_count < TABLE_DEPTH) begin
              known_clients[known_count] = r.client_address;
              known_count++;
              r.newly_added = 1'b1;
            end else begin
              r.dropped_full = 1'b1;
            end
          end
        end
      end
      CMD_CLEAR: begin
        known_count = 0;
      end
      CMD_READ: begin
        if (it.read_index < known_count) r.entry_address = known_clients[it.read_index];
      end
      default: begin
      end
    endcase
    r.entry_count = known_count[6:0];
    return r;
  endfunction

  // Mirrors a register write; unused indexes change nothing.
  function automatic void apply_reg_write(cac_cfg_item_t w);
    if (w.reg_index == CFG_ENABLE) shadow_enable = w.wdata[0];
    else if (w.reg_index == CFG_TARGET) shadow_target = w.wdata;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    errors++;
    $display("%0t mismatch in %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Input driver: predicts each item at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_reports = {expected_reports, track_client_table(in_ch.data)};
      if (!in_ch.valid || in_ch.ready) begin
        if (frames_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= frames_to_send.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Register write driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_ch.valid <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg_write(cfg_ch.data);
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (reg_writes.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          cfg_ch.valid <= 1'b1;
          cfg_ch.data  <= reg_writes.pop_front();
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: each accepted report is checked against the oldest prediction.
  always @(posedge clk) begin
    cac_out_item_t want;
    cac_out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report, client_address", got.client_address, '0);
      end else begin
        want = expected_reports.pop_front();
        if (got.client_found !== want.client_found)
          report_mismatch("client_found", ADDR_W'(got.client_found),
                          ADDR_W'(want.client_found));
        if (got.client_address !== want.client_address)
          report_mismatch("client_address", got.client_address, want.client_address);
        if (got.newly_added !== want.newly_added)
          report_mismatch("newly_added", ADDR_W'(got.newly_added),
                          ADDR_W'(want.newly_added));
        if (got.dropped_full !== want.dropped_full)
          report_mismatch("dropped_full", ADDR_W'(got.dropped_full),
                          ADDR_W'(want.dropped_full));
        if (got.entry_count !== want.entry_count)
          report_mismatch("entry_count", ADDR_W'(got.entry_count),
                          ADDR_W'(want.entry_count));
        if (got.entry_address !== want.entry_address)
          report_mismatch("entry_address", got.entry_address, want.entry_address);
      end
    end
  end

  function automatic logic [ADDR_W-1:0] random_address();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[ADDR_W-1:0];
  endfunction

  task automatic queue_frame(logic [1:0] cmd, logic [1:0] kind, logic [LEN_W-1:0] len,
                             logic [ADDR_W-1:0] a1, logic [ADDR_W-1:0] a2,
                             logic [5:0] idx);
    cac_in_item_t it;
    it.command      = cmd;
    it.frame_kind   = kind;
    it.frame_length = len;
    it.addr_one     = a1;
    it.addr_two     = a2;
    it.read_index   = idx;
    frames_to_send = {frames_to_send, it};
  endtask

  task automatic queue_reg_write(logic [1:0] idx, logic [ADDR_W-1:0] value);
    cac_cfg_item_t w;
    w.reg_index = idx;
    w.wdata     = value;
    reg_writes = {reg_writes, w};
  endtask

  // Waits until everything sent has been accepted and answered.
  task automatic wait_idle();
    do @(negedge clk);
    while (frames_to_send.size() != 0 || in_ch.valid || reg_writes.size() != 0
           || cfg_ch.valid || expected_reports.size() != 0);
  endtask

  // Reprograms both registers once the block is quiet.
  task automatic start_phase(logic en, logic [ADDR_W-1:0] target);
    logic [ADDR_W-1:0] noise;
    wait_idle();
    repeat (CFG_PAUSE) @(posedge clk);
    noise = random_address();
    queue_reg_write(CFG_ENABLE, {noise[ADDR_W-1:1], en});
    queue_reg_write(CFG_TARGET, target);
    wait_idle();
  endtask

  // Mostly frames between the target and a pool of stations, plus noise,
  // reads, clears and no-op commands.
  task automatic queue_random_frames(int count, int pool_size, int clear_pct,
                                     logic [ADDR_W-1:0] target);
    logic [ADDR_W-1:0] pool[POOL_MAX];
    logic [ADDR_W-1:0] station;
    logic [ADDR_W-1:0] a1;
    logic [ADDR_W-1:0] a2;
    logic [LEN_W-1:0]  len;
    int                n;
    int                roll;
    for (n = 0; n < pool_size; n++) pool[n] = random_address();
    pool[0] = BROADCAST_ADDR;
    pool[1] = '0;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 55) begin
        station = pool[$urandom_range(pool_size - 1)];
        len = ($urandom_range(99) < 90) ? LEN_W'($urandom_range(4095, MIN_FRAME_BYTES))
                                        : LEN_W'($urandom_range(MIN_FRAME_BYTES - 1));
        if ($urandom_range(1)) queue_frame(CMD_OBSERVE, 2'($urandom_range(1)), len,
                                           target, station, 6'($urandom_range(63)));
        else queue_frame(CMD_OBSERVE, 2'($urandom_range(1)), len,
                         station, target, 6'($urandom_range(63)));
      end else if (roll < 70) begin
        a1 = random_address();
        a2 = random_address();
        if ($urandom_range(99) < 30) a1 = target;
        else if ($urandom_range(99) < 30) a2 = target;
        queue_frame(CMD_OBSERVE, 2'($urandom_range(3)), LEN_W'($urandom_range(4095)),
                    a1, a2, 6'($urandom_range(63)));
      end else if (roll < 85) begin
        queue_frame(CMD_READ, 2'($urandom_range(3)), LEN_W'($urandom_range(4095)),
                    random_address(), random_address(), 6'($urandom_range(63)));
      end else if (roll < 85 + clear_pct) begin
        queue_frame(CMD_CLEAR, 2'($urandom_range(3)), LEN_W'($urandom_range(4095)),
                    random_address(), random_address(), 6'($urandom_range(63)));
      end else begin
        queue_frame(2'($urandom_range(3)), 2'($urandom_range(3)),
                    LEN_W'($urandom_range(4095)), random_address(), random_address(),
                    6'($urandom_range(63)));
      end
    end
  endtask

  // Stimulus and end of run.
  initial begin
    logic [ADDR_W-1:0] ap;
    logic [ADDR_W-1:0] sta_a;
    logic [ADDR_W-1:0] sta_b;
    logic [ADDR_W-1:0] sta_c;
    logic [ADDR_W-1:0] sta_d;

    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    steady        = 1'b0;
    errors        = 0;
    cycles        = 0;
    known_count   = 0;
    shadow_enable = 1'b0;
    shadow_target = '0;
    foreach (known_clients[i]) known_clients[i] = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    ap    = random_address();
    sta_a = random_address();
    sta_b = random_address();
    sta_c = random_address();
    sta_d = random_address();

    // Disabled: a valid client frame is ignored.
    start_phase(1'b0, ap);
    queue_frame(CMD_OBSERVE, KIND_MGMT, LEN_W'(MIN_FRAME_BYTES), ap, sta_a, 6'd0);
    queue_frame(CMD_READ, KIND_MGMT, '0, '0, '0, 6'd0);

    // Enabled: both directions, duplicates, broadcast, filtered kinds and lengths.
    start_phase(1'b1, ap);
    queue_frame(CMD_OBSERVE, KIND_MGMT, LEN_W'(MIN_FRAME_BYTES), ap, sta_a, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_DATA, '1, sta_b, ap, 6'd63);
    queue_frame(CMD_OBSERVE, KIND_DATA, 12'd100, sta_a, ap, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_MGMT, LEN_W'(MIN_FRAME_BYTES), ap, ap, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_MGMT, LEN_W'(MIN_FRAME_BYTES), BROADCAST_ADDR, ap, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_DATA, 12'd60, ap, BROADCAST_ADDR, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_OTHER, 12'd100, ap, sta_c, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_RESERVED, 12'd100, ap, sta_c, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_MGMT, LEN_W'(MIN_FRAME_BYTES - 1), ap, sta_c, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_DATA, '0, ap, sta_c, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_MGMT, LEN_W'(MIN_FRAME_BYTES), sta_c, sta_d, 6'd0);
    queue_frame(CMD_READ, KIND_MGMT, '0, '0, '0, 6'd0);
    queue_frame(CMD_READ, KIND_MGMT, '0, '0, '0, 6'd2);
    queue_frame(CMD_READ, KIND_MGMT, '0, '0, '0, 6'd3);
    queue_frame(CMD_READ, KIND_MGMT, '1, '1, '1, 6'd63);
    queue_frame(CMD_NOP, KIND_DATA, 12'd200, ap, sta_d, 6'd1);
    queue_frame(CMD_CLEAR, KIND_MGMT, '0, '0, '0, 6'd0);
    queue_frame(CMD_READ, KIND_MGMT, '0, '0, '0, 6'd0);
    queue_frame(CMD_OBSERVE, KIND_MGMT, LEN_W'(MIN_FRAME_BYTES), ap, sta_b, 6'd0);
    queue_frame(CMD_READ, KIND_MGMT, '0, '0, '0, 6'd0);

    // Random target, small pool of stations.
    start_phase(1'b1, random_address());
    queue_random_frames(150, 12, 3, shadow_target);

    // All-zero target, large pool and clears only among random commands: the table fills and drops.
    start_phase(1'b1, '0);
    queue_random_frames(300, 100, 0, shadow_target);

    // All-ones target, with neither side idling.
    start_phase(1'b1, BROADCAST_ADDR);
    steady = 1'b1;
    queue_random_frames(150, 20, 5, shadow_target);

    // Disabled again; writes to unused register indexes must change nothing.
    start_phase(1'b0, random_address());
    steady = 1'b0;
    queue_reg_write(CFG_SPARE_A, random_address());
    queue_reg_write(CFG_SPARE_B, random_address());
    wait_idle();
    queue_random_frames(80, 16, 3, shadow_target);

    // Random target, large pool, rare clears.
    start_phase(1'b1, random_address());
    queue_random_frames(300, 90, 1, shadow_target);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cac_pkg.sv
hw/rtl/cac_chan_if.sv
hw/rtl/cac_client_mem.sv
hw/rtl/cac_frame_filter.sv
hw/rtl/cac_ctrl.sv
hw/rtl/wlan_client_address_collector.sv
dv/tb_wlan_client_address_collector.sv
